[hdl/assert_macros.svh]
// Assertion macros for the RTL of the Modbus RTU request framer.
// No dependencies; included by the framer core, which carries the concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define MRF_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("framer check failed");

// Check a property on every rising clock edge, reset included.
`define MRF_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("framer check failed");

`endif

[hdl/mrf_pkg.sv]
// Package for the Modbus RTU request framer: payload structs, frame codes
// and the CRC-16 lookup table. No dependencies.
package mrf_pkg;

  // Operation select and the matching Modbus function codes
  localparam logic       OP_READ_HOLD   = 1'b0;
  localparam logic       OP_WRITE_ONE   = 1'b1;
  localparam logic [7:0] FUNC_READ_HOLD = 8'h03;
  localparam logic [7:0] FUNC_WRITE_ONE = 8'h06;

  // Frame layout
  localparam int unsigned FRAME_LEN = 8;
  localparam int unsigned BODY_LEN  = 6;
  localparam int unsigned IDX_W     = $clog2(FRAME_LEN);

  localparam logic [IDX_W-1:0] BYTE_SLAVE    = IDX_W'(0);
  localparam logic [IDX_W-1:0] BYTE_FUNC     = IDX_W'(1);
  localparam logic [IDX_W-1:0] BYTE_REG_HI   = IDX_W'(2);
  localparam logic [IDX_W-1:0] BYTE_REG_LO   = IDX_W'(3);
  localparam logic [IDX_W-1:0] BYTE_OPD_HI   = IDX_W'(4);
  localparam logic [IDX_W-1:0] BYTE_OPD_LO   = IDX_W'(5);
  localparam logic [IDX_W-1:0] BYTE_CRC_LO   = IDX_W'(6);
  localparam logic [IDX_W-1:0] BYTE_CRC_HI   = IDX_W'(7);
  localparam logic [IDX_W-1:0] BYTE_BODY_END = IDX_W'(BODY_LEN);

  // CRC-16 (reflected 0xA001), preset all ones
  localparam logic [15:0] CRC_PRESET = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;

  // One request item
  typedef struct packed {
    logic        op;
    logic [7:0]  slave_address;
    logic [15:0] register_address;
    logic [15:0] operand_word;
  } mrf_req_t;

  // One frame byte
  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last_byte;
  } mrf_byte_t;

  typedef logic [15:0] crc_table_t [256];

  // Byte-wise CRC table, built at elaboration
  function automatic crc_table_t build_crc_table();
    crc_table_t  tab;
    logic [15:0] c;
    for (int i = 0; i < 256; i++) begin
      c = 16'(i);
      for (int b = 0; b < 8; b++) begin
        c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      tab[i] = c;
    end
    return tab;
  endfunction

  localparam crc_table_t CRC_TABLE = build_crc_table();

endpackage

[hdl/mrf_crc_step.sv]
// One table-driven Modbus CRC-16 update for a single byte.
// Depends on mrf_pkg for the lookup table.
module mrf_crc_step (
  input  logic [15:0] crc,
  input  logic [7:0]  data,
  output logic [15:0] crc_next
);
  import mrf_pkg::*;

  // Shift out the low byte and fold in the table entry
  assign crc_next = {8'h00, crc[15:8]} ^ CRC_TABLE[crc[7:0] ^ data];

endmodule

[hdl/modbus_rtu_request_framer_core.sv]
// Top level of the Modbus RTU request framer: request register, byte
// sequencer, CRC accumulation and the result register.
// Depends on mrf_pkg, mrf_crc_step and assert_macros.svh.
`include "assert_macros.svh"

// A request is taken at a rising edge with start high and busy low. Its eight
// frame bytes (slave address, function code, register address hi/lo, operand
// hi/lo, CRC low, CRC high) come out on result, one per cycle on consecutive
// cycles, each marked by strobe for exactly one cycle; the first appears once
// the transfer has passed the active/idx registers and the result register,
// and the eighth carries last_byte. The receiver cannot hold bytes off, so it
// must take one every cycle. Busy drops in the cycle the eighth byte is
// selected, so a new request may be taken then and its frame follows with no
// gap. The CRC is updated one byte per cycle as the body goes out. Reset
// clears the sequencer; no clearing pass is needed.
module modbus_rtu_request_framer_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  mrf_pkg::mrf_req_t request,
  output logic              strobe,
  output mrf_pkg::mrf_byte_t result
);
  import mrf_pkg::*;

  logic             active;
  logic [IDX_W-1:0] idx;
  mrf_req_t         req;
  logic [15:0]      crc;
  logic [15:0]      crc_upd;
  logic [7:0]       cur_byte;
  logic             accept;
  logic             frame_end;

  assign frame_end = active && (idx == BYTE_CRC_HI);
  assign busy      = active && !frame_end;
  assign accept    = start && !busy;

  // Select the frame byte for the current position
  always_comb begin
    case (idx)
      BYTE_SLAVE:  cur_byte = req.slave_address;
      BYTE_FUNC:   cur_byte = (req.op == OP_WRITE_ONE) ? FUNC_WRITE_ONE : FUNC_READ_HOLD;
      BYTE_REG_HI: cur_byte = req.register_address[15:8];
      BYTE_REG_LO: cur_byte = req.register_address[7:0];
      BYTE_OPD_HI: cur_byte = req.operand_word[15:8];
      BYTE_OPD_LO: cur_byte = req.operand_word[7:0];
      BYTE_CRC_LO: cur_byte = crc[7:0];
      BYTE_CRC_HI: cur_byte = crc[15:8];
      default:     cur_byte = 8'h00;
    endcase
  end

  mrf_crc_step u_crc_step (
    .crc      (crc),
    .data     (cur_byte),
    .crc_next (crc_upd)
  );

  // Sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      idx    <= BYTE_SLAVE;
      strobe <= 1'b0;
    end else begin
      strobe <= active;
      if (accept) begin
        active <= 1'b1;
        idx    <= BYTE_SLAVE;
      end else if (active) begin
        idx <= idx + IDX_W'(1);
        // Frame done with no request waiting: go idle
        if (frame_end) begin
          active <= 1'b0;
        end
      end
    end
  end

  // Request capture, CRC accumulation and result register
  always_ff @(posedge clk) begin
    if (accept) begin
      req <= request;
      crc <= CRC_PRESET;
    end else if (active && (idx < BYTE_BODY_END)) begin
      crc <= crc_upd;
    end
    result.tx_byte   <= cur_byte;
    result.last_byte <= frame_end;
  end

  // A frame end is never followed directly by another frame end
  `MRF_ASSERT(a_last_single, (strobe && result.last_byte) |=> !(strobe && result.last_byte))
  // An accepted request shows its first byte after the sequencer and result registers
  `MRF_ASSERT(a_first_byte, (start && !busy) |=> ##1 (strobe && !result.last_byte))
  // While busy, a byte goes out in the next cycle
  `MRF_ASSERT(a_busy_emits, busy |=> strobe)
  // The last byte closes a run of eight strobes
  `MRF_ASSERT(a_run_len, (strobe && result.last_byte) |-> ($past(strobe, 7) && !$past(result.last_byte, 1)))

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for modbus_rtu_request_framer_core: queue-fed request
// driver, byte monitor and a frame/CRC predictor. Depends on mrf_pkg and the RTL.

module tb_top;
  import mrf_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_WAIT  = 20;
  localparam int unsigned RAND_PER_PHASE = 125;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  logic      busy;
  mrf_req_t  request = '0;
  logic      strobe;
  mrf_byte_t result;

  mrf_req_t    pending_requests [$];
  mrf_byte_t   expected_bytes [$];
  int unsigned sender_idle_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  modbus_rtu_request_framer_core u_top (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .request(request),
    .strobe (strobe),
    .result (result)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic flag_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  // Build the eight bytes of one request frame, CRC low byte before CRC high byte
  task automatic frame_request(input mrf_req_t req);
    logic [7:0]  body [BODY_LEN];
    logic [15:0] crc;
    mrf_byte_t   b;
    body[0] = req.slave_address;
    body[1] = (req.op == OP_WRITE_ONE) ? FUNC_WRITE_ONE : FUNC_READ_HOLD;
    body[2] = req.register_address[15:8];
    body[3] = req.register_address[7:0];
    body[4] = req.operand_word[15:8];
    body[5] = req.operand_word[7:0];
    crc = CRC_PRESET;
    for (int k = 0; k < BODY_LEN; k++) begin
      crc = crc ^ {8'h00, body[k]};
      for (int j = 0; j < 8; j++) begin
        crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
      end
    end
    for (int k = 0; k < BODY_LEN; k++) begin
      b.tx_byte   = body[k];
      b.last_byte = 1'b0;
      expected_bytes.push_back(b);
    end
    b.tx_byte   = crc[7:0];
    b.last_byte = 1'b0;
    expected_bytes.push_back(b);
    b.tx_byte   = crc[15:8];
    b.last_byte = 1'b1;
    expected_bytes.push_back(b);
  endtask

  // Driver: hold a request until its transfer, then fetch the next or idle
  always @(posedge clk) begin
    if (rst) begin
      start   <= 1'b0;
      request <= '0;
    end else if (start && busy) begin
      start <= 1'b1;
    end else if (pending_requests.size() != 0 &&
                 $urandom_range(0, 99) >= sender_idle_pct) begin
      request <= pending_requests.pop_front();
      start   <= 1'b1;
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: check each strobed byte, then record a newly accepted request
  always @(posedge clk) begin
    mrf_byte_t exp_b;
    if (!rst) begin
      if (strobe) begin
        if (expected_bytes.size() == 0) begin
          flag_mismatch($sformatf("unexpected byte %02h last=%0b",
                                  result.tx_byte, result.last_byte));
        end else begin
          exp_b = expected_bytes.pop_front();
          if (result.tx_byte !== exp_b.tx_byte)
            flag_mismatch($sformatf("tx_byte got %02h want %02h",
                                    result.tx_byte, exp_b.tx_byte));
          if (result.last_byte !== exp_b.last_byte)
            flag_mismatch($sformatf("last_byte got %0b want %0b",
                                    result.last_byte, exp_b.last_byte));
        end
      end
      if (start && !busy) frame_request(request);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("modbus_rtu_request_framer_core verification failed");
      $finish;
    end
  end

  function automatic mrf_req_t make_req(input logic op, input logic [7:0] sa,
                                        input logic [15:0] ra,
                                        input logic [15:0] od);
    mrf_req_t r;
    r.op               = op;
    r.slave_address    = sa;
    r.register_address = ra;
    r.operand_word     = od;
    return r;
  endfunction

  task automatic wait_drained();
    while (pending_requests.size() != 0 || start || expected_bytes.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    mrf_req_t r;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: field extremes, both operations, odd counts and raw negatives
    pending_requests.push_back(make_req(OP_READ_HOLD, 8'h00, 16'h0000, 16'h0000));
    pending_requests.push_back(make_req(OP_WRITE_ONE, 8'h00, 16'h0000, 16'h0000));
    pending_requests.push_back(make_req(OP_READ_HOLD, 8'hFF, 16'hFFFF, 16'hFFFF));
    pending_requests.push_back(make_req(OP_WRITE_ONE, 8'hFF, 16'hFFFF, 16'hFFFF));
    pending_requests.push_back(make_req(OP_READ_HOLD, 8'h01, 16'h0000, 16'h0001));
    pending_requests.push_back(make_req(OP_READ_HOLD, 8'h11, 16'h006B, 16'h007D));
    pending_requests.push_back(make_req(OP_READ_HOLD, 8'h11, 16'h006B, 16'h007E));
    pending_requests.push_back(make_req(OP_WRITE_ONE, 8'h11, 16'h0001, 16'h8000));
    pending_requests.push_back(make_req(OP_WRITE_ONE, 8'hAA, 16'hAAAA, 16'h5555));
    pending_requests.push_back(make_req(OP_READ_HOLD, 8'h55, 16'h5555, 16'hAAAA));
    pending_requests.push_back(make_req(OP_WRITE_ONE, 8'h80, 16'h8000, 16'h7FFF));
    pending_requests.push_back(make_req(OP_READ_HOLD, 8'h7F, 16'h7FFF, 16'h8000));
    wait_drained();

    // Random: no idling, sender idle 59, sender full rate, sender idle 27
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: sender_idle_pct = 0;
        1: sender_idle_pct = 59;
        2: sender_idle_pct = 0;
        default: sender_idle_pct = 27;
      endcase
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        r.op               = 1'($urandom_range(0, 1));
        r.slave_address    = 8'($urandom);
        r.register_address = 16'($urandom);
        r.operand_word     = 16'($urandom);
        pending_requests.push_back(r);
      end
      wait_drained();
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    if (expected_bytes.size() != 0)
      flag_mismatch($sformatf("%0d bytes never arrived", expected_bytes.size()));
    if (mismatch_count == 0) begin
      $display("modbus_rtu_request_framer_core verification clean");
    end else begin
      $display("modbus_rtu_request_framer_core verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hdl
hdl/mrf_pkg.sv
hdl/mrf_crc_step.sv
hdl/modbus_rtu_request_framer_core.sv
tb/sv/tb_top.sv
